FILE: src/mm4_pkg.sv
`timescale 1ns / 1ps
package mm4_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int IDX_W            = 6;
  localparam int DW               = 32;
  localparam int PW               = 64;
  localparam int IN_TDATA_W       = 104;
  localparam int OUT_TDATA_W      = 72;
  localparam int OUT_PAD          = OUT_TDATA_W - IDX_W - 2 * DW;
  localparam int RND_FULL_SH      = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

  localparam logic [DW-1:0]        STEP_RESET = DW'(64'd1 << FRAC_BITS);
  localparam logic signed [PW-1:0] HALF_RND   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [PW-1:0] FULL_RND   = 64'sd1 <<< RND_FULL_SH;
  localparam logic signed [PW-1:0] SAT_HI     = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PW-1:0] SAT_LO     = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [PW-1:0] ONE        = 64'sd1;

  typedef enum logic [1:0] {
    REQ_PASS = 2'd0,
    REQ_HALF = 2'd1,
    REQ_FULL = 2'd2,
    REQ_COMB = 2'd3
  } req_t;

  typedef struct packed {
    req_t                  req_type;
    logic [IDX_W-1:0]      element_index;
    logic signed [DW-1:0]  position;
    logic signed [DW-1:0]  velocity;
    logic signed [DW-1:0]  acceleration;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]      result_index;
    logic signed [DW-1:0]  new_position;
    logic signed [DW-1:0]  new_velocity;
    logic                  full_step_factor;
  } res_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] x);
    if (x > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (x < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return x[DW-1:0];
  endfunction

  // x * H / 2, round to nearest, ties up
  function automatic logic signed [PW-1:0] rnd_half(input logic signed [PW-1:0] x);
    return (x + HALF_RND) >>> (FRAC_BITS + 1);
  endfunction

  // x * H, round to nearest, ties up
  function automatic logic signed [PW-1:0] rnd_full(input logic signed [PW-1:0] x);
    if (FRAC_BITS == 0) begin
      return x;
    end
    return (x + FULL_RND) >>> FRAC_BITS;
  endfunction

  // signed value times unsigned step, exact in 64 bits
  function automatic logic signed [PW-1:0] mul_step(input logic signed [DW-1:0] x,
                                                     input logic [DW-1:0] h);
    logic signed [PW+1:0] m;
    m = $signed({x[DW-1], x}) * $signed({1'b0, h});
    return m[PW-1:0];
  endfunction

endpackage

FILE: src/mm4_ram.sv
`timescale 1ns / 1ps
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mm4_pipe.sv
`timescale 1ns / 1ps
module mm4_pipe #(
  parameter int MAX_ELEMENTS = mm4_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [mm4_pkg::DW-1:0] step,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  mm4_pkg::item_t        in_item,
  output logic                  res_vld,
  output mm4_pkg::res_t         res
);
  import mm4_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  // --- hazard check: an entry is read only after its pending write lands
  function automatic logic conflict(input logic vld, input req_t wreq,
                                    input logic [IDX_W-1:0] widx, input item_t it);
    logic rd_a;
    logic rd_b;
    rd_a = (it.req_type == REQ_FULL) || (it.req_type == REQ_COMB);
    rd_b = (it.req_type == REQ_COMB);
    return vld && (widx == it.element_index) &&
           ((rd_a && wreq == REQ_HALF) || (rd_b && wreq == REQ_FULL));
  endfunction

  logic                 s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  item_t                s1_r;
  logic                 s1_inr_r, s2_inr_r, s3_inr_r;
  req_t                 s2_req_r, s3_req_r, s4_req_r, s5_req_r, s6_req_r;
  logic [IDX_W-1:0]     s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r, s6_idx_r;
  logic signed [DW:0]   s2_bp_r, s2_bv_r, s3_bp_r, s3_bv_r, s4_hp_r, s5_hp_r, s6_hp_r;
  logic signed [PW-1:0] s2_mv_r, s2_ma_r, s3_tv_r, s3_ta_r, s5_m_r, s6_t_r;
  logic signed [DW-1:0] s4_np_r, s4_nv_r, s5_np_r, s5_nv_r, s6_np_r, s6_nv_r;

  logic                 hazard, acc, in_range;
  logic                 ra_en, rb_en, wa_en, wb_en;
  logic [4*DW-1:0]      a_rdata, a_q, wa_data;
  logic [2*DW-1:0]      b_rdata, b_q, wb_data;
  logic signed [DW:0]   s1_bp, s1_bv;
  logic signed [PW-1:0] s2_tv, s2_ta, s3_sp, s3_sv, s3_avg;
  logic signed [DW-1:0] s3_np, s3_nv, s6_fin;

  assign hazard = conflict(s1_vld_r, s1_r.req_type, s1_r.element_index, in_item) ||
                  conflict(s2_vld_r, s2_req_r, s2_idx_r, in_item) ||
                  conflict(s3_vld_r, s3_req_r, s3_idx_r, in_item);
  assign in_tready = en && !hazard;
  assign acc       = in_tvalid && in_tready;
  assign in_range  = 32'(in_item.element_index) < 32'(MAX_ELEMENTS);

  assign ra_en = acc && ((in_item.req_type == REQ_FULL) || (in_item.req_type == REQ_COMB));
  assign rb_en = acc && (in_item.req_type == REQ_COMB);

  // A entry: {half velocity, half position, start velocity, start position}
  mm4_ram #(.WIDTH(4 * DW), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_ram_a (
    .clk   (clk),
    .we    (wa_en),
    .waddr (AW'(s3_idx_r)),
    .wdata (wa_data),
    .re    (ra_en),
    .raddr (AW'(in_item.element_index)),
    .rdata (a_rdata)
  );

  // B entry: {full velocity, full position}
  mm4_ram #(.WIDTH(2 * DW), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_ram_b (
    .clk   (clk),
    .we    (wb_en),
    .waddr (AW'(s3_idx_r)),
    .wdata (wb_data),
    .re    (rb_en),
    .raddr (AW'(in_item.element_index)),
    .rdata (b_rdata)
  );

  // --- S1: pick base values, multiply by step
  always_comb begin
    a_q = s1_inr_r ? a_rdata : '0;
    b_q = s1_inr_r ? b_rdata : '0;
    case (s1_r.req_type)
      REQ_FULL: begin
        s1_bp = {a_q[DW-1], a_q[DW-1:0]};
        s1_bv = {a_q[2*DW-1], a_q[2*DW-1:DW]};
      end
      REQ_COMB: begin
        s1_bp = $signed({a_q[3*DW-1], a_q[3*DW-1:2*DW]}) +
                $signed({b_q[DW-1], b_q[DW-1:0]});
        s1_bv = $signed({a_q[4*DW-1], a_q[4*DW-1:3*DW]}) +
                $signed({b_q[2*DW-1], b_q[2*DW-1:DW]});
      end
      default: begin
        s1_bp = {s1_r.position[DW-1], s1_r.position};
        s1_bv = {s1_r.velocity[DW-1], s1_r.velocity};
      end
    endcase
  end

  // --- S2: round the scaled terms
  always_comb begin
    s2_tv = (s2_req_r == REQ_FULL) ? rnd_full(s2_mv_r) : rnd_half(s2_mv_r);
    s2_ta = (s2_req_r == REQ_FULL) ? rnd_full(s2_ma_r) : rnd_half(s2_ma_r);
  end

  // --- S3: sums, saturation, memory write-back
  always_comb begin
    s3_sp  = PW'(s3_bp_r) + s3_tv_r;
    s3_sv  = PW'(s3_bv_r) + s3_ta_r;
    s3_avg = (s3_sv + ONE) >>> 1;
    case (s3_req_r)
      REQ_HALF, REQ_FULL: begin
        s3_np = sat32(s3_sp);
        s3_nv = sat32(s3_sv);
      end
      REQ_COMB: begin
        s3_np = s3_bp_r[DW-1:0];
        s3_nv = sat32(s3_avg);
      end
      default: begin
        s3_np = s3_bp_r[DW-1:0];
        s3_nv = s3_bv_r[DW-1:0];
      end
    endcase
  end

  assign wa_en   = en && s3_vld_r && s3_inr_r && (s3_req_r == REQ_HALF);
  assign wb_en   = en && s3_vld_r && s3_inr_r && (s3_req_r == REQ_FULL);
  assign wa_data = {s3_nv, s3_np, s3_bv_r[DW-1:0], s3_bp_r[DW-1:0]};
  assign wb_data = {s3_nv, s3_np};

  // --- S6: final combine of position
  assign s6_fin = sat32((PW'(s6_hp_r) + s6_t_r + ONE) >>> 1);

  always_comb begin
    res_vld                = s6_vld_r;
    res.result_index       = s6_idx_r;
    res.new_position       = (s6_req_r == REQ_COMB) ? s6_fin : s6_np_r;
    res.new_velocity       = s6_nv_r;
    res.full_step_factor   = (s6_req_r != REQ_HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (acc) begin
        s1_r     <= in_item;
        s1_inr_r <= in_range;
      end
      s2_req_r <= s1_r.req_type;
      s2_idx_r <= s1_r.element_index;
      s2_inr_r <= s1_inr_r;
      s2_bp_r  <= s1_bp;
      s2_bv_r  <= s1_bv;
      s2_mv_r  <= mul_step(s1_r.velocity, step);
      s2_ma_r  <= mul_step(s1_r.acceleration, step);

      s3_req_r <= s2_req_r;
      s3_idx_r <= s2_idx_r;
      s3_inr_r <= s2_inr_r;
      s3_bp_r  <= s2_bp_r;
      s3_bv_r  <= s2_bv_r;
      s3_tv_r  <= s2_tv;
      s3_ta_r  <= s2_ta;

      s4_req_r <= s3_req_r;
      s4_idx_r <= s3_idx_r;
      s4_np_r  <= s3_np;
      s4_nv_r  <= s3_nv;
      s4_hp_r  <= s3_bp_r;

      s5_req_r <= s4_req_r;
      s5_idx_r <= s4_idx_r;
      s5_np_r  <= s4_np_r;
      s5_nv_r  <= s4_nv_r;
      s5_hp_r  <= s4_hp_r;
      s5_m_r   <= mul_step(s4_nv_r, step);

      s6_req_r <= s5_req_r;
      s6_idx_r <= s5_idx_r;
      s6_np_r  <= s5_np_r;
      s6_nv_r  <= s5_nv_r;
      s6_hp_r  <= s5_hp_r;
      s6_t_r   <= rnd_half(s5_m_r);
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_vld_r)
    else $error("accepted transfer did not enter the pipeline");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(s1_vld_r) && $stable(s6_vld_r)))
    else $error("pipeline moved while stalled");

  a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (wa_en && ra_en) |-> (s3_idx_r != in_item.element_index))
    else $error("read of an entry with its write still pending");
`endif

endmodule

FILE: src/mm4_oskid.sv
`timescale 1ns / 1ps
module mm4_oskid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_vld,
  input  mm4_pkg::res_t res,
  output logic          en,
  output logic          out_tvalid,
  input  logic          out_tready,
  output mm4_pkg::res_t out_res
);
  import mm4_pkg::*;

  logic out_vld_r, skd_vld_r;
  res_t out_r, skd_r;
  logic take, out_free;

  assign en         = !skd_vld_r;
  assign take       = en && res_vld;
  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_res    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skd_vld_r) begin
        out_vld_r <= 1'b1;
        skd_vld_r <= 1'b0;
      end else begin
        out_vld_r <= take;
      end
    end else if (take) begin
      skd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skd_vld_r ? skd_r : res;
    end else if (take) begin
      // hold the result aside while the output is stalled
      skd_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_vld_r |-> out_vld_r)
    else $error("skid holds a result while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skd_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid filled without an output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_r)))
    else $error("stalled output transfer changed");
`endif

endmodule

FILE: src/mm4_second_order_integrator_step_unit.sv
`timescale 1ns / 1ps
// Channel  | valid / ready          | payload
// ---------+------------------------+-----------------------------------------
// in       | in_tvalid / in_tready  | in_tuser: req_type; in_tdata: item
// out      | out_tvalid / out_tready| out_tuser: full_step_factor; out_tdata
// cfg      | cfg_valid / cfg_ready  | cfg_data: step_size
//
// One item per cycle while in_tready is high. A req_type 2 or 3 item whose element
// has a pending write to a memory it reads, from one of the three items accepted
// before it, is held off by in_tready until that write lands.
// Reset (rst_n low, synchronous) empties the pipeline and sets step_size to 1.0.
// A stalled output holds the pipeline once the skid register is full.
module mm4_second_order_integrator_step_unit #(
  parameter int MAX_ELEMENTS = mm4_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] element_index, [37:6] position, [69:38] velocity,
  // [101:70] acceleration, [103:102] zero
  input  logic [mm4_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] req_type
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [5:0] result_index, [37:6] new_position, [69:38] new_velocity, [71:70] zero
  output logic [mm4_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] full_step_factor
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mm4_pkg::DW-1:0]             cfg_data
);
  import mm4_pkg::*;

  logic [DW-1:0] step_r;
  item_t         in_item;
  logic          en, res_vld;
  res_t          res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_r <= cfg_data;
    end
  end

  always_comb begin
    in_item.req_type      = req_t'(in_tuser);
    in_item.element_index = in_tdata[IDX_W-1:0];
    in_item.position      = in_tdata[IDX_W +: DW];
    in_item.velocity      = in_tdata[IDX_W + DW +: DW];
    in_item.acceleration  = in_tdata[IDX_W + 2 * DW +: DW];
  end

  mm4_pipe #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .step      (step_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .res_vld   (res_vld),
    .res       (res)
  );

  mm4_oskid u_oskid (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, out_res.new_velocity, out_res.new_position,
                      out_res.result_index};
  assign out_tuser = out_res.full_step_factor;

endmodule
